FILE: hw/rtl/tse_pkg.sv
// Shared types, register indexes and the divisor function of the Taylor series evaluator.
// Used by taylor_series_evaluator and tse_div_step.
package tse_pkg;

    localparam int ARG_W  = 32;   // Q4.28 argument
    localparam int SUM_W  = 64;   // Q36.28 terms and sum
    localparam int ACC_W  = 128;  // exact product of term, |x| and a second factor (|x| for sin and cos)
    localparam int DVD_W  = 80;   // rounded dividend, ten digits of eight bits
    localparam int DIG_W  = 8;    // quotient bits per divide cycle
    localparam int DIV_W  = 15;   // twice the largest per-term divisor
    localparam int CNT_W  = 7;    // term counter, holds up to 127
    localparam int NIDX_W = 6;    // term number used by the divisor

    localparam logic [SUM_W-1:0] ONE_Q28 = SUM_W'(64'h0000_0000_1000_0000);
    localparam logic [SUM_W-1:0] MAX_POS = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] MAX_NEG = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_SIN = 2'd0,
        MODE_COS = 2'd1,
        MODE_LN  = 2'd2,
        MODE_EXP = 2'd3
    } t_mode;

    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_TERM_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_SETUP,
        S_MUL,
        S_ACC,
        S_DIVPREP,
        S_DIV,
        S_ROUND,
        S_ADD,
        S_FINISH
    } t_state;

    // Twice the divisor of term n: the rounded quotient is floor((a + d) / 2d).
    function automatic logic [DIV_W-1:0] f_divisor2(input t_mode mode,
                                                    input logic [NIDX_W-1:0] n);
        logic [7:0]       two_n;
        logic [13:0]      prod;
        logic [DIV_W-2:0] div;
        two_n = {1'b0, n, 1'b0};
        prod  = '0;
        div   = '0;
        case (mode)
            MODE_SIN: begin
                prod = 14'(two_n * (two_n + 8'd1));
                div  = prod;
            end
            MODE_COS: begin
                prod = 14'(two_n * (two_n - 8'd1));
                div  = prod;
            end
            MODE_LN:  div = 14'({1'b0, n} + 7'd1);
            MODE_EXP: div = 14'(n);
            default:  div = '0;
        endcase
        return {div, 1'b0};
    endfunction

endpackage

FILE: hw/rtl/tse_div_step.sv
// One cycle of the term divider: eight restoring quotient bits against a small constant divisor.
// Depends on tse_pkg for widths.
module tse_div_step (
    input  logic [tse_pkg::DIV_W-1:0] i_rem,
    input  logic [tse_pkg::DIG_W-1:0] i_bits,
    input  logic [tse_pkg::DIV_W-1:0] i_divisor,
    output logic [tse_pkg::DIV_W-1:0] o_rem,
    output logic [tse_pkg::DIG_W-1:0] o_quot
);
    import tse_pkg::*;

    always_comb begin
        logic [DIV_W:0]   r;
        logic [DIG_W-1:0] q;
        r = {1'b0, i_rem};
        q = '0;
        for (int i = DIG_W - 1; i >= 0; i--) begin
            r = {r[DIV_W-1:0], i_bits[i]};
            if (r >= {1'b0, i_divisor}) begin
                r    = r - {1'b0, i_divisor};
                q[i] = 1'b1;
            end
        end
        o_rem  = r[DIV_W-1:0];
        o_quot = q;
    end

endmodule

FILE: hw/rtl/taylor_series_evaluator.sv
// Top level of the Taylor series evaluator: sequencer, shared 32x32 multiplier and term datapath.
// Depends on tse_pkg and tse_div_step.
//
// Usage: a transaction on the input channel (i_in_valid, o_in_stall, i_x_arg) carries one Q4.28
// argument; one transaction on the output channel (o_out_valid, i_out_stall) returns the Q36.28
// partial sum and an overflow flag. The user must write registers mode and term_count through
// i_cfg_we / i_cfg_index / i_cfg_data only while the block is idle; not enforced by the block.
// One item is worked on at a time; o_in_stall is high from acceptance until the result is
// placed in the output register, which can still hold the previous, untaken result.
// The term_count is clamped to MAX_TERMS; with zero terms the sequencer goes from idle
// straight to finish. Each term after the first passes through setup, five limb products
// through the one 32x32 multiplier (each a multiply and an accumulate step), the rounding
// offset, ten quotient digits from the eight-bit-per-cycle divider, clamping and summing.
// Reset (synchronous, active low) returns mode to sin, term_count to 16, and empties the
// output register. When the receiver stalls, the result is held; a finished item waits
// in the sequencer until the output register is free.
module taylor_series_evaluator #(
    parameter int MAX_TERMS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [5:0]                i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [tse_pkg::ARG_W-1:0] i_x_arg,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [tse_pkg::SUM_W-1:0] o_series_sum,
    output logic                      o_overflow
);
    import tse_pkg::*;

    t_state r_state, n_state;

    t_mode              r_mode;
    logic [5:0]         r_term_count;
    logic [ARG_W-1:0]   r_x;
    logic [ARG_W-1:0]   r_xm;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_term;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ovf;
    logic               r_sign;
    logic [DIV_W-1:0]   r_d2;
    logic [ARG_W-1:0]   r_mul_b;
    logic [ACC_W-1:0]   r_src;
    logic [ACC_W-1:0]   r_acc;
    logic [63:0]        r_prod;
    logic [1:0]         r_limb;
    logic               r_pass;
    logic [DVD_W-1:0]   r_dvd;
    logic [DIV_W-1:0]   r_rem;
    logic [3:0]         r_dig;
    logic               r_out_valid;
    logic [SUM_W-1:0]   r_out_sum;
    logic               r_out_ovf;

    logic               in_accept;
    logic               out_free;
    logic [CNT_W-1:0]   count_clamped;
    logic [ARG_W-1:0]   x_mag;
    logic [ARG_W-1:0]   mult_b;
    logic [ARG_W-1:0]   mult_a;
    logic [ACC_W-1:0]   acc_next;
    logic               limb_last;
    logic [72:0]        dvd_base;
    logic [DIV_W-1:0]   div_rem;
    logic [DIG_W-1:0]   div_quot;
    logic               q_over;
    logic [SUM_W-1:0]   q_clamped;
    logic [SUM_W-1:0]   term_new;
    logic [SUM_W-1:0]   sum_raw;
    logic               sum_over;
    logic [SUM_W-1:0]   sum_new;
    logic [SUM_W-1:0]   term_first;
    logic               last_term;

    // Handshake and control strobes.
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        in_accept  = i_in_valid && (r_state == S_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        limb_last  = r_pass ? (r_limb == 2'd2) : (r_limb == 2'd1);
        last_term  = ((r_n + CNT_W'(1)) == r_count);
    end

    assign o_out_valid  = r_out_valid;
    assign o_series_sum = r_out_sum;
    assign o_overflow   = r_out_ovf;

    // Datapath combinational pieces.
    always_comb begin
        count_clamped = ({1'b0, r_term_count} > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                                 : {1'b0, r_term_count};
        x_mag      = i_x_arg[ARG_W-1] ? (ARG_W'(0) - i_x_arg) : i_x_arg;
        mult_b     = r_pass ? r_mul_b : r_xm;
        mult_a     = r_src[{r_limb, 5'b0} +: 32];
        acc_next   = r_acc + ({64'b0, r_prod} << {r_limb, 5'b0});
        dvd_base   = (r_mode == MODE_SIN || r_mode == MODE_COS) ? r_acc[127:55] : r_acc[99:27];
        q_over     = (r_dvd > {16'b0, (r_sign ? MAX_NEG : MAX_POS)});
        q_clamped  = q_over ? (r_sign ? MAX_NEG : MAX_POS) : r_dvd[SUM_W-1:0];
        term_new   = r_sign ? (SUM_W'(0) - q_clamped) : q_clamped;
        sum_raw    = r_sum + r_term;
        sum_over   = (r_sum[SUM_W-1] == r_term[SUM_W-1]) && (sum_raw[SUM_W-1] != r_sum[SUM_W-1]);
        sum_new    = sum_over ? (r_sum[SUM_W-1] ? MAX_NEG : MAX_POS) : sum_raw;
        term_first = (r_mode == MODE_SIN || r_mode == MODE_LN) ?
                     {{(SUM_W-ARG_W){r_x[ARG_W-1]}}, r_x} : ONE_Q28;
    end

    tse_div_step u_div_step (
        .i_rem     (r_rem),
        .i_bits    (r_dvd[DVD_W-1 -: DIG_W]),
        .i_divisor (r_d2),
        .o_rem     (div_rem),
        .o_quot    (div_quot)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) begin
                           n_state = (count_clamped == '0) ? S_FINISH : S_FIRST;
                       end
            S_FIRST:   n_state = (r_count == CNT_W'(1)) ? S_FINISH : S_SETUP;
            S_SETUP:   n_state = S_MUL;
            S_MUL:     n_state = S_ACC;
            S_ACC:     n_state = (limb_last && r_pass) ? S_DIVPREP : S_MUL;
            S_DIVPREP: n_state = S_DIV;
            S_DIV:     n_state = (r_dig == 4'd9) ? S_ROUND : S_DIV;
            S_ROUND:   n_state = S_ADD;
            S_ADD:     n_state = last_term ? S_FINISH : S_SETUP;
            S_FINISH:  n_state = out_free ? S_IDLE : S_FINISH;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_SIN;
            r_term_count <= 6'd16;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:       r_mode       <= t_mode'(i_cfg_data[1:0]);
                    REG_TERM_COUNT: r_term_count <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (r_state == S_FINISH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Term datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_x     <= i_x_arg;
                    r_xm    <= x_mag;
                    r_count <= count_clamped;
                    r_sum   <= '0;
                    r_ovf   <= 1'b0;
                end
            end
            S_FIRST: begin
                r_term <= term_first;
                r_sum  <= term_first;
                r_n    <= CNT_W'(1);
            end
            S_SETUP: begin
                r_src  <= {64'b0, (r_term[SUM_W-1] ? (SUM_W'(0) - r_term) : r_term)};
                r_acc  <= '0;
                r_limb <= 2'd0;
                r_pass <= 1'b0;
                r_d2   <= f_divisor2(r_mode, r_n[NIDX_W-1:0]);
                case (r_mode)
                    MODE_SIN, MODE_COS: begin
                        r_mul_b <= r_xm;
                        r_sign  <= !r_term[SUM_W-1];
                    end
                    MODE_LN: begin
                        r_mul_b <= ARG_W'(r_n);
                        r_sign  <= !(r_term[SUM_W-1] ^ r_x[ARG_W-1]);
                    end
                    default: begin
                        r_mul_b <= ARG_W'(1);
                        r_sign  <= r_term[SUM_W-1] ^ r_x[ARG_W-1];
                    end
                endcase
            end
            S_MUL: begin
                r_prod <= 64'(mult_a * mult_b);
            end
            S_ACC: begin
                if (limb_last && !r_pass) begin
                    // The first product becomes the operand of the second pass.
                    r_src  <= acc_next;
                    r_acc  <= '0;
                    r_limb <= 2'd0;
                    r_pass <= 1'b1;
                end else begin
                    r_acc  <= acc_next;
                    r_limb <= r_limb + 2'd1;
                end
            end
            S_DIVPREP: begin
                // Rounding half away from zero reduces to floor((a + d) / 2d).
                r_dvd <= {7'b0, dvd_base} + DVD_W'(r_d2[DIV_W-1:1]);
                r_rem <= '0;
                r_dig <= 4'd0;
            end
            S_DIV: begin
                r_rem <= div_rem;
                r_dvd <= {r_dvd[DVD_W-DIG_W-1:0], div_quot};
                r_dig <= r_dig + 4'd1;
            end
            S_ROUND: begin
                r_term <= term_new;
                if (q_over) begin
                    r_ovf <= 1'b1;
                end
            end
            S_ADD: begin
                r_sum <= sum_new;
                r_n   <= r_n + CNT_W'(1);
                if (sum_over) begin
                    r_ovf <= 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    r_out_sum <= r_sum;
                    r_out_ovf <= r_ovf;
                end
            end
            default: ;
        endcase
    end

endmodule
